[rtl/mrt_pkg.sv]
package mrt_pkg;

    // Op kinds by the argument bytes they take.
    localparam logic [2:0] KIND_NONE    = 3'd0;
    localparam logic [2:0] KIND_PLAIN   = 3'd1;
    localparam logic [2:0] KIND_RAW1    = 3'd2;
    localparam logic [2:0] KIND_POS1    = 3'd3;
    localparam logic [2:0] KIND_POS_RAW = 3'd4;
    localparam logic [2:0] KIND_RAW_RAW = 3'd5;
    localparam logic [2:0] KIND_POS_POS = 3'd6;

    // Parser phases.
    localparam logic [1:0] PH_OP      = 2'd0;
    localparam logic [1:0] PH_ARG1    = 2'd1;
    localparam logic [1:0] PH_ARG2    = 2'd2;
    localparam logic [1:0] PH_COMMENT = 2'd3;

    // Special characters and the position base for letters.
    localparam logic [7:0] CH_HASH        = 8'h23;
    localparam logic [7:0] CH_SPACE       = 8'h20;
    localparam logic [7:0] CH_QUOTE       = 8'h27;
    localparam logic [7:0] POS_ALPHA_BASE = 8'd10;

    // Configuration register indexes and reset values.
    localparam logic CFG_DROP_EMPTY = 1'b0;
    localparam logic CFG_TRUNC_CODE = 1'b1;
    localparam logic       DROP_EMPTY_RESET = 1'b1;
    localparam logic [7:0] TRUNC_CODE_RESET = 8'd39;

    // One result beat.
    typedef struct packed {
        logic       rule_end;
        logic [7:0] arg_second;
        logic [7:0] arg_first;
        logic [7:0] op_code;
    } t_result;

    // Results of one input beat, handed from parser to result queue.
    typedef struct packed {
        logic [1:0] count;
        t_result    second;
        t_result    first;
    } t_push;

    function automatic logic [2:0] classify(input logic [7:0] c);
        logic [2:0] kind;
        unique case (c) inside
            ":", "l", "u", "c", "C", "t", "r", "d", "f", "{", "}", "k", "K", "M",
            "4", "6":
                kind = KIND_PLAIN;
            "$", "^", "@", "!", "/":
                kind = KIND_RAW1;
            "D", "T", "+", "-", "p", "<", ">", CH_QUOTE:
                kind = KIND_POS1;
            "i", "o":
                kind = KIND_POS_RAW;
            "s":
                kind = KIND_RAW_RAW;
            "x", "O":
                kind = KIND_POS_POS;
            default:
                kind = KIND_NONE;
        endcase
        return kind;
    endfunction

    // Digits give 0..9, letters of either case give 10..35, anything else 0.
    function automatic logic [7:0] decode_pos(input logic [7:0] c);
        logic [7:0] v;
        if (c >= "0" && c <= "9") begin
            v = c - "0";
        end else if (c >= "A" && c <= "Z") begin
            v = c - "A" + POS_ALPHA_BASE;
        end else if (c >= "a" && c <= "z") begin
            v = c - "a" + POS_ALPHA_BASE;
        end else begin
            v = 8'd0;
        end
        return v;
    endfunction

endpackage

[rtl/mrt_parser.sv]
module mrt_parser (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_beat,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_drop_empty,
    input  logic [7:0]        i_trunc_code,
    output mrt_pkg::t_push    o_push
);

    logic [1:0] r_phase, n_phase;
    logic [7:0] r_held_op, n_held_op;
    logic [7:0] r_held_arg, n_held_arg;
    logic [7:0] r_held_raw, n_held_raw;
    logic       r_any, n_any;

    logic       take;
    logic       op_v;
    logic [7:0] op_chr;
    logic [7:0] a1;
    logic [7:0] a2;
    logic       term_v;
    logic [2:0] kind_held;
    logic [2:0] kind_byte;
    mrt_pkg::t_result op_res;
    mrt_pkg::t_result term_res;

    assign kind_held = mrt_pkg::classify(r_held_op);
    assign kind_byte = mrt_pkg::classify(i_byte);

    // Phase update and op emission for one byte.
    always_comb begin
        n_phase    = r_phase;
        n_held_op  = r_held_op;
        n_held_arg = r_held_arg;
        n_held_raw = r_held_raw;
        take       = 1'b0;
        op_v       = 1'b0;
        op_chr     = r_held_op;
        a1         = 8'd0;
        a2         = 8'd0;

        unique case (r_phase)
            mrt_pkg::PH_OP: begin
                take = 1'b1;
            end
            mrt_pkg::PH_ARG1: begin
                n_phase = mrt_pkg::PH_OP;
                if (kind_held == mrt_pkg::KIND_RAW1) begin
                    op_v = 1'b1;
                    a1   = i_byte;
                end else if (kind_held == mrt_pkg::KIND_POS1) begin
                    op_v = 1'b1;
                    a1   = mrt_pkg::decode_pos(i_byte);
                end else if (kind_held >= mrt_pkg::KIND_POS_RAW) begin
                    if (i_last) begin
                        // Second byte missing: reparse this byte as an op.
                        take = 1'b1;
                    end else begin
                        n_held_raw = i_byte;
                        n_held_arg = mrt_pkg::decode_pos(i_byte);
                        n_phase    = mrt_pkg::PH_ARG2;
                    end
                end
            end
            mrt_pkg::PH_ARG2: begin
                n_phase = mrt_pkg::PH_OP;
                if (kind_held >= mrt_pkg::KIND_POS_RAW) begin
                    op_v = 1'b1;
                    a1   = (kind_held == mrt_pkg::KIND_RAW_RAW) ? r_held_raw : r_held_arg;
                    a2   = (kind_held == mrt_pkg::KIND_POS_POS) ?
                           mrt_pkg::decode_pos(i_byte) : i_byte;
                end
            end
            default: begin
            end
        endcase

        // The byte stands in op position.
        if (take) begin
            if (i_byte == mrt_pkg::CH_HASH) begin
                n_phase = mrt_pkg::PH_COMMENT;
            end else if (i_byte == mrt_pkg::CH_SPACE) begin
                n_phase = mrt_pkg::PH_OP;
            end else if (kind_byte == mrt_pkg::KIND_PLAIN) begin
                op_v   = 1'b1;
                op_chr = i_byte;
            end else if (kind_byte != mrt_pkg::KIND_NONE && !i_last) begin
                n_held_op = i_byte;
                n_phase   = mrt_pkg::PH_ARG1;
            end
        end

        n_any  = r_any | op_v;
        term_v = i_last & (n_any | ~i_drop_empty);

        // Every line starts fresh.
        if (i_last) begin
            n_phase    = mrt_pkg::PH_OP;
            n_held_op  = 8'd0;
            n_held_arg = 8'd0;
            n_held_raw = 8'd0;
            n_any      = 1'b0;
        end
    end

    // Result beats of this byte, op first and terminator after it.
    always_comb begin
        op_res.op_code    = (op_chr == mrt_pkg::CH_QUOTE) ? i_trunc_code : op_chr;
        op_res.arg_first  = a1;
        op_res.arg_second = a2;
        op_res.rule_end   = 1'b0;
        term_res          = '0;
        term_res.rule_end = 1'b1;

        o_push.first  = op_v ? op_res : term_res;
        o_push.second = term_res;
        o_push.count  = i_beat ? ({1'b0, op_v} + {1'b0, term_v}) : 2'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= mrt_pkg::PH_OP;
            r_held_op  <= 8'd0;
            r_held_arg <= 8'd0;
            r_held_raw <= 8'd0;
            r_any      <= 1'b0;
        end else if (i_beat) begin
            r_phase    <= n_phase;
            r_held_op  <= n_held_op;
            r_held_arg <= n_held_arg;
            r_held_raw <= n_held_raw;
            r_any      <= n_any;
        end
    end

endmodule

[rtl/mrt_result_fifo.sv]
module mrt_result_fifo (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mrt_pkg::t_push    i_push,
    input  logic              i_pop,
    output logic              o_room,
    output logic              o_valid,
    output mrt_pkg::t_result  o_head
);

    mrt_pkg::t_result r_mem [4];
    logic [1:0] r_wr_ptr, r_rd_ptr;
    logic [2:0] r_count;
    logic       do_pop;
    logic [1:0] wr_next;

    assign o_valid = (r_count != 3'd0);
    assign o_head  = r_mem[r_rd_ptr];
    // Room for the two beats a single byte can produce.
    assign o_room  = (r_count <= 3'd2);
    assign do_pop  = i_pop & o_valid;
    assign wr_next = r_wr_ptr + 2'd1;

    // Entry storage, up to two writes per cycle.
    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.first;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.second;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            r_wr_ptr <= r_wr_ptr + i_push.count;
            r_rd_ptr <= r_rd_ptr + {1'b0, do_pop};
            r_count  <= r_count + {1'b0, i_push.count} - {2'b00, do_pop};
        end
    end

endmodule

[rtl/mangling_rule_tokenizer_unit.sv]
// Mangling rule tokenizer: takes rule text one byte per beat, with tlast on the
// last byte of each line, and returns one beat per parsed op (op code with its
// two decoded arguments) plus a terminator beat with tlast set at each line end.
// Lines without ops get no terminator while drop_empty_rules is set. Each input
// beat is parsed combinationally, so bytes are taken every cycle unless stalled. A byte
// that completes an op at line end yields two output beats, and the four-entry result
// queue stalls input only while it holds three or more beats; output drains at one
// beat per cycle while m_axis_tready is high. Configuration writes are taken at any
// time through the write port and should be made while the stream is idle.
module mangling_rule_tokenizer_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // line_last
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // [7:0] op_code, [15:8] arg_first, [23:16] arg_second
    output logic        m_axis_tlast,   // rule_end
    // Configuration writes.
    input  logic        i_cfg_we,
    input  logic        i_cfg_index,
    input  logic [7:0]  i_cfg_wdata
);

    logic             r_drop_empty;
    logic [7:0]       r_trunc_code;
    logic             in_beat;
    logic             room;
    mrt_pkg::t_push   push;
    mrt_pkg::t_result head;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drop_empty <= mrt_pkg::DROP_EMPTY_RESET;
            r_trunc_code <= mrt_pkg::TRUNC_CODE_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                mrt_pkg::CFG_DROP_EMPTY: r_drop_empty <= i_cfg_wdata[0];
                mrt_pkg::CFG_TRUNC_CODE: r_trunc_code <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign s_axis_tready = room;
    assign in_beat       = s_axis_tvalid & room;

    mrt_parser u_parser (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat       (in_beat),
        .i_byte       (s_axis_tdata),
        .i_last       (s_axis_tlast),
        .i_drop_empty (r_drop_empty),
        .i_trunc_code (r_trunc_code),
        .o_push       (push)
    );

    mrt_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (m_axis_tready),
        .o_room  (room),
        .o_valid (m_axis_tvalid),
        .o_head  (head)
    );

    assign m_axis_tdata = {head.arg_second, head.arg_first, head.op_code};
    assign m_axis_tlast = head.rule_end;

endmodule
